// File: src/bolt_pkg.sv
// ----------------------------------------------------------------------------
// bolt_pkg
// Shared types, sizes and helper functions of the bounded ordered list table.
// ----------------------------------------------------------------------------
package bolt_pkg;

    // Storage sizing.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths of the item channels.
    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int FOUND_W  = 6;
    localparam int ENTRY_W  = 7;
    localparam int STATUS_W = 2;

    // Width that holds both a request position and the entry count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 3'd0,
        K_INSERT = 3'd1,
        K_DELETE = 3'd2,
        K_READ   = 3'd3,
        K_FIND   = 3'd4
    } t_kind;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_DEL,
        S_RD,
        S_DONE
    } t_state;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic [VALUE_W-1:0] data_out;
        logic [FOUND_W-1:0] found_position;
        logic [ENTRY_W-1:0] entry_count;
        t_status            status;
    } t_result;

    // Port of the list memory as driven by the sequencer.
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

    // Sign-extend a stored word and keep the low 32 bits.
    function automatic logic [VALUE_W-1:0] sext_out(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] ext;
        ext = 64'(signed'(w));
        return ext[VALUE_W-1:0];
    endfunction

    // Keep the low bits of a request word that the list stores.
    function automatic logic [DATA_WIDTH-1:0] store_word(input logic [VALUE_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[DATA_WIDTH-1:0];
    endfunction

endpackage

// File: src/bolt_ifs.sv
// ----------------------------------------------------------------------------
// bolt item channels
// Valid/ready channels carrying request and result items of the list table.
// ----------------------------------------------------------------------------
interface bolt_req_if import bolt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface bolt_rsp_if import bolt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] data_out;
    logic [FOUND_W-1:0]        found_position;
    logic [ENTRY_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, data_out, found_position, entry_count, status,
                    input ready);
    modport sink   (input valid, data_out, found_position, entry_count, status,
                    output ready);
endinterface

// File: src/bolt_ram.sv
// ----------------------------------------------------------------------------
// bolt_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bolt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/bolt_seq.sv
// ----------------------------------------------------------------------------
// bolt_seq
// Request sequencer: holds the entry count and walks the list memory one
// entry a cycle to search, open a gap for an insert or close one on delete.
// ----------------------------------------------------------------------------
module bolt_seq import bolt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bolt_req_if.sink              i_req,
    output t_mem_req              o_mem,
    input  logic [DATA_WIDTH-1:0] i_rdata,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_res_take
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]     r_ptr, n_ptr;
    logic                  r_issue, n_issue;
    logic                  r_lag, n_lag;
    logic [ADDR_W-1:0]     r_lag_addr, n_lag_addr;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic                  r_del, n_del;
    t_result               r_res, n_res;

    logic [CMP_W-1:0] req_pos;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] tgt_pos;
    logic [CNT_W-1:0] last_idx;
    logic             accept;

    assign accept   = i_req.valid && i_req.ready;
    assign req_pos  = CMP_W'(i_req.position);
    assign cnt_ext  = CMP_W'(r_count);
    assign last_idx = r_count - CNT_W'(1);
    assign tgt_pos  = (i_req.kind == K_APPEND) ? cnt_ext : req_pos;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_lag   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_lag   <= n_lag;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_lag_addr <= n_lag_addr;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_del      <= n_del;
        r_res      <= n_res;
    end

    // Next state, memory accesses and result.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_issue    = r_issue;
        n_lag      = r_lag;
        n_lag_addr = r_lag_addr;
        n_val      = r_val;
        n_pos      = r_pos;
        n_del      = r_del;
        n_res      = r_res;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_pos;
        o_mem.wdata = r_val;
        o_mem.raddr = r_ptr;

        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_res;
        o_res.entry_count = ENTRY_W'(r_count);

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                // A read fetches its entry while the item is taken.
                o_mem.raddr = ADDR_W'(i_req.position);
                if (accept) begin
                    n_val   = store_word(i_req.value);
                    n_pos   = ADDR_W'(i_req.position);
                    n_lag   = 1'b0;
                    n_res   = '0;
                    n_res.status = ST_OK;
                    unique case (i_req.kind)
                        K_APPEND, K_INSERT: begin
                            if (tgt_pos > cnt_ext) begin
                                n_res.status = ST_BAD_POS;
                                n_state      = S_DONE;
                            end else if (r_count >= CNT_W'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                // Walk down from the tail, moving each entry up one place.
                                n_pos   = ADDR_W'(tgt_pos);
                                n_ptr   = ADDR_W'(last_idx);
                                n_issue = (tgt_pos < cnt_ext);
                                n_state = S_INS;
                            end
                        end
                        K_DELETE, K_FIND: begin
                            n_del   = (i_req.kind == K_DELETE);
                            n_ptr   = '0;
                            n_issue = (r_count != '0);
                            n_state = S_SCAN;
                        end
                        K_READ: begin
                            if (req_pos < cnt_ext) begin
                                n_state = S_RD;
                            end else begin
                                n_res.status = ST_BAD_POS;
                                n_state      = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_INS: begin
                if (r_issue) begin
                    n_lag      = 1'b1;
                    n_lag_addr = r_ptr;
                    if (r_ptr == r_pos) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr - ADDR_W'(1);
                    end
                end else begin
                    n_lag = 1'b0;
                end
                if (r_lag) begin
                    // Entry read last cycle goes one place towards the tail.
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_lag_addr + ADDR_W'(1);
                    o_mem.wdata = i_rdata;
                end else if (!r_issue) begin
                    // Gap is open: place the new word.
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pos;
                    o_mem.wdata = r_val;
                    n_count     = r_count + CNT_W'(1);
                    n_state     = S_DONE;
                end
            end

            S_SCAN: begin
                if (r_issue) begin
                    n_lag      = 1'b1;
                    n_lag_addr = r_ptr;
                    if (CNT_W'(r_ptr) == last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + ADDR_W'(1);
                    end
                end else begin
                    n_lag = 1'b0;
                end
                if (r_lag && (i_rdata == r_val)) begin
                    if (r_del) begin
                        // First match found: pull the later entries down over it.
                        n_ptr   = r_lag_addr + ADDR_W'(1);
                        n_issue = (CNT_W'(r_lag_addr) != last_idx);
                        n_lag   = 1'b0;
                        n_state = S_DEL;
                    end else begin
                        n_res.found_position = FOUND_W'(r_lag_addr);
                        n_state              = S_DONE;
                    end
                end else if (!r_issue && !r_lag) begin
                    n_res.status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end
            end

            S_DEL: begin
                if (r_issue) begin
                    n_lag      = 1'b1;
                    n_lag_addr = r_ptr;
                    if (CNT_W'(r_ptr) == last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + ADDR_W'(1);
                    end
                end else begin
                    n_lag = 1'b0;
                end
                if (r_lag) begin
                    // Entry read last cycle goes one place towards the head.
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_lag_addr - ADDR_W'(1);
                    o_mem.wdata = i_rdata;
                end else if (!r_issue) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_RD: begin
                n_res.data_out = sext_out(i_rdata);
                n_state        = S_DONE;
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/bounded_ordered_list_table.sv
// Each request passes through the sequencer and then the output register. A rejected
// request or a spare kind goes straight to its result; a read fetches one entry; an append
// or insert moves the entries from the tail down to its position up one place; a find
// scans from the head; a delete scans for its first match, then pulls the later ones down.
// One item at a time: a request is taken only while the sequencer is idle, so a held
// result stalls the next one. Reset clears the entry count and state, not the list memory.
// ----------------------------------------------------------------------------
// bounded_ordered_list_table
// Ordered list of signed words kept packed in one memory, with append,
// insert, delete, read and find requests and one result item per request.
// ----------------------------------------------------------------------------
module bounded_ordered_list_table import bolt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bolt_req_if.sink  i_req,
    bolt_rsp_if.source o_rsp
);

    t_mem_req              mem_req;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic                  res_valid;
    t_result               res;
    logic                  res_take;

    logic    r_out_valid;
    t_result r_out;

    // List memory.
    bolt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Request sequencer.
    bolt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // The output register takes a result when it is empty or being drained.
    assign res_take = res_valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    // Result item.
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.data_out       = r_out.data_out;
    assign o_rsp.found_position = r_out.found_position;
    assign o_rsp.entry_count    = r_out.entry_count;
    assign o_rsp.status         = r_out.status;

endmodule

// File: tb/tb_bounded_ordered_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_table
// Self-checking bench for the ordered list table. A scoreboard keeps its own
// copy of the list and predicts the result of every accepted request. Each
// result item is compared field by field with the oldest prediction. Requests
// run through a directed opening and then random phases that grow the list
// to full, shrink it to empty and throw noise at it. Both sides idle at random outside the noise phase.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list_table;
    import bolt_pkg::*;

    // Kinds that the block does not decode.
    localparam logic [KIND_W-1:0] K_SPARE5 = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE7 = 3'd7;

    localparam longint CYCLE_LIMIT = 1000000;
    localparam int     PHASE_ITEMS = 350;
    localparam int     SETTLE_CYCLES = 80;

    // Request mixes of the random phases.
    typedef enum {
        MIX_BALANCED,
        MIX_GROW,
        MIX_SHRINK,
        MIX_NOISE
    } mix_t;

    // One result item as the block should give it.
    typedef struct {
        logic [VALUE_W-1:0]  data_out;
        logic [FOUND_W-1:0]  found_position;
        logic [ENTRY_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } list_result_t;

    // Keeps a copy of the list, predicts each result and checks the block.
    class list_table_scoreboard;
        logic [DATA_WIDTH-1:0] words [CAPACITY];
        int unsigned           total;
        list_result_t          awaited [$];
        int unsigned           mismatches;
        int unsigned           results_seen;

        function new();
            total        = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // First position below the count that holds the word.
        function bit locate(input logic [DATA_WIDTH-1:0] w, output int unsigned where);
            where = 0;
            for (int i = 0; i < total; i++) begin
                if (words[i] == w) begin
                    where = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Apply an accepted request to the copy and queue its result.
        function void note_request(input logic [KIND_W-1:0] kind,
                                   input logic [POS_W-1:0] pos,
                                   input logic [VALUE_W-1:0] value);
            list_result_t          r;
            logic [DATA_WIDTH-1:0] w;
            int unsigned           target;
            int unsigned           where;
            r.data_out       = '0;
            r.found_position = '0;
            r.status         = ST_OK;
            w                = DATA_WIDTH'(value);
            case (kind)
                K_APPEND, K_INSERT: begin
                    target = (kind == K_APPEND) ? total : int'(pos);
                    // The position check takes precedence over the full check.
                    if (target > total) begin
                        r.status = ST_BAD_POS;
                    end else if (total >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = total; i > target; i--) words[i] = words[i-1];
                        words[target] = w;
                        total++;
                    end
                end
                K_DELETE: begin
                    if (locate(w, where)) begin
                        for (int i = where; i + 1 < total; i++) words[i] = words[i+1];
                        total--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                K_READ: begin
                    if (pos < total) r.data_out = VALUE_W'(signed'(words[pos]));
                    else r.status = ST_BAD_POS;
                end
                K_FIND: begin
                    if (locate(w, where)) r.found_position = FOUND_W'(where);
                    else r.status = ST_NOT_FOUND;
                end
                default: begin
                    // Spare kinds leave the list alone.
                end
            endcase
            r.entry_count = ENTRY_W'(total);
            awaited.push_back(r);
        endfunction

        // Compare one result item with the oldest prediction.
        function void check_result(input list_result_t got);
            list_result_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no request pending: data %h found %0d count %0d status %0d",
                             results_seen, got.data_out, got.found_position,
                             got.entry_count, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.data_out !== want.data_out ||
                got.found_position !== want.found_position ||
                got.entry_count !== want.entry_count ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected data %h found %0d count %0d status %0d, got data %h found %0d count %0d status %0d",
                             results_seen, want.data_out, want.found_position,
                             want.entry_count, want.status, got.data_out,
                             got.found_position, got.entry_count, got.status);
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bolt_req_if req_ch ();
    bolt_rsp_if rsp_ch ();

    bounded_ordered_list_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    list_table_scoreboard board;
    bit                   calm;
    int unsigned          stall_left;
    longint               cycles;
    logic [VALUE_W-1:0]   value_pool [8];

    // Clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // All inputs known from the start.
    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        stall_left      = 0;
        cycles          = 0;
        calm            = 1'b0;
        board           = new();
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_bounded_ordered_list_table: errors");
            $finish;
        end
    end

    // Result monitor: check each accepted item and draw the next stall.
    always @(posedge i_clk) begin
        list_result_t got;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.data_out       = rsp_ch.data_out;
            got.found_position = rsp_ch.found_position;
            got.entry_count    = rsp_ch.entry_count;
            got.status         = rsp_ch.status;
            board.check_result(got);
            stall_left = calm ? 0 : $urandom_range(0, 9);
        end
    end

    // Result ready, lowered for the drawn number of cycles after each item.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Offer one request after a random gap and note it once accepted.
    // Entered and left just after a falling edge.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.position <= pos;
        req_ch.value    <= value;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        board.note_request(kind, pos, value);
        @(negedge i_clk);
    endtask

    // One random request shaped by the phase mix.
    task automatic send_random(input mix_t mix);
        int unsigned        roll;
        int unsigned        pool_pct;
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                kind = roll < 35 ? K_APPEND : roll < 70 ? K_INSERT :
                       roll < 75 ? K_DELETE : roll < 90 ? K_READ : K_FIND;
            MIX_SHRINK:
                kind = roll < 5 ? K_APPEND : roll < 10 ? K_INSERT :
                       roll < 60 ? K_DELETE : roll < 80 ? K_READ : K_FIND;
            MIX_NOISE:
                kind = KIND_W'($urandom_range(0, 7));
            default:
                kind = roll < 20 ? K_APPEND : roll < 40 ? K_INSERT :
                       roll < 60 ? K_DELETE : roll < 80 ? K_READ : K_FIND;
        endcase
        // Positions mostly within reach of the list, sometimes anywhere.
        if (mix == MIX_NOISE || $urandom_range(0, 99) < 15)
            pos = POS_W'($urandom_range(0, 127));
        else
            pos = POS_W'($urandom_range(0, board.total));
        // Values mostly ones already held or from a small pool, so that
        // deletes and finds hit often.
        pool_pct = (mix == MIX_NOISE) ? 55 : 85;
        roll = $urandom_range(0, 99);
        if (roll < 30 && board.total > 0)
            value = VALUE_W'(board.words[$urandom_range(0, board.total - 1)]);
        else if (roll < pool_pct)
            value = value_pool[$urandom_range(0, 7)];
        else
            value = $urandom;
        send_request(kind, pos, value);
    endtask

    task automatic run_phase(input mix_t mix, input int items, input bit no_idle);
        calm = no_idle;
        repeat (items) send_random(mix);
        calm = 1'b0;
    endtask

    // Hold the sender back until every predicted result has come.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
    endtask

    // Stimulus.
    initial begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Requests on an empty list.
        send_request(K_READ,   7'd0,   32'h0000_0000);
        send_request(K_FIND,   7'd0,   32'h0000_0000);
        send_request(K_DELETE, 7'd0,   32'h0000_0005);
        send_request(K_INSERT, 7'd1,   32'h0000_0001);
        // Build a short list with the extreme words and a duplicate.
        send_request(K_INSERT, 7'd0,   32'h8000_0000);
        send_request(K_APPEND, 7'd0,   32'h7FFF_FFFF);
        send_request(K_APPEND, 7'd0,   32'hFFFF_FFFF);
        send_request(K_INSERT, 7'd3,   32'h0000_0000);
        send_request(K_INSERT, 7'd1,   32'h1234_5678);
        send_request(K_APPEND, 7'd127, 32'h0000_0000);
        // Reads at the head, the tail, the count and beyond.
        send_request(K_READ,   7'd0,   32'h0000_0000);
        send_request(K_READ,   7'd5,   32'hFFFF_FFFF);
        send_request(K_READ,   7'd6,   32'h0000_0000);
        send_request(K_READ,   7'd127, 32'h0000_0000);
        // Finds of a duplicate, an extreme and an absent word.
        send_request(K_FIND,   7'd0,   32'h0000_0000);
        send_request(K_FIND,   7'd0,   32'h7FFF_FFFF);
        send_request(K_FIND,   7'd0,   32'h55AA_55AA);
        // Deletes of the first duplicate and of an absent word.
        send_request(K_DELETE, 7'd0,   32'h0000_0000);
        send_request(K_DELETE, 7'd0,   32'h1111_1111);
        send_request(K_FIND,   7'd0,   32'h0000_0000);
        // Insert far past the count, then the spare kinds.
        send_request(K_INSERT, 7'd127, 32'hFFFF_FFFF);
        send_request(K_SPARE5, 7'd127, 32'hFFFF_FFFF);
        send_request(K_SPARE6, 7'd64,  32'h8000_0000);
        send_request(K_SPARE7, 7'd0,   32'h0000_0000);

        // Random phases: mixed, fill to full, noise without idling, empty out.
        run_phase(MIX_BALANCED, PHASE_ITEMS, 1'b0);
        run_phase(MIX_GROW,     PHASE_ITEMS, 1'b0);
        drain_results();
        run_phase(MIX_NOISE,    PHASE_ITEMS, 1'b1);
        run_phase(MIX_SHRINK,   PHASE_ITEMS, 1'b0);
        drain_results();
        run_phase(MIX_BALANCED, PHASE_ITEMS, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("tb_bounded_ordered_list_table: clean");
        end else begin
            $display("tb_bounded_ordered_list_table: errors");
        end
        $finish;
    end

endmodule
